// ===== hw/rtl/backlight_inactivity_sleep_controller_defines.svh =====
// Assertion macros used by the backlight sleep controller top level.
`ifndef BACKLIGHT_INACTIVITY_SLEEP_CONTROLLER_DEFINES_SVH
`define BACKLIGHT_INACTIVITY_SLEEP_CONTROLLER_DEFINES_SVH

// Same-cycle implication, checked out of reset.
`define BISC_ASSERT_NOW(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked out of reset.
`define BISC_ASSERT_NEXT(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== hw/rtl/bisc_pkg.sv =====
// Types, constants and helper functions of the backlight sleep controller.
`default_nettype none

package bisc_pkg;

    typedef enum logic [2:0] {
        OP_TICK      = 3'd0,
        OP_ACTIVITY  = 3'd1,
        OP_TOUCH     = 3'd2,
        OP_SET_LEVEL = 3'd3,
        OP_WAKE      = 3'd4
    } op_t;

    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 11;

    localparam logic [CFG_IDX_W-1:0] CFG_SLEEP_TIMEOUT     = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_STORED_BRIGHTNESS = 2'd1;

    localparam logic [6:0]  PCT_MIN         = 7'd10;
    localparam logic [6:0]  PCT_MAX         = 7'd97;
    localparam logic [6:0]  PCT_RESET       = 7'd60;
    localparam int          TIMEOUT_RESET   = 120;
    localparam int          MS_PER_SEC      = 1000;
    // ceil(2^22 / 97): exact quotient for every numerator below 2^15
    localparam logic [15:0] DRIVE_RECIP     = 16'd43241;
    localparam logic [14:0] DRIVE_ROUND     = 15'd48;

    typedef struct packed {
        logic [2:0] operation;
        logic       pressed;
        logic [7:0] percent;
        logic       persist;
    } in_item_t;

    typedef struct packed {
        logic [7:0] backlight_level;
        logic       asleep;
        logic       touch_consumed;
        logic       save_request;
        logic [6:0] save_value;
    } out_item_t;

    typedef struct packed {
        logic                  valid;
        logic [CFG_IDX_W-1:0]  index;
        logic [CFG_DATA_W-1:0] data;
    } cfg_write_t;

    function automatic logic [6:0] clamp_pct(input logic [7:0] p);
        logic [6:0] r;
        if (p < {1'b0, PCT_MIN}) begin
            r = PCT_MIN;
        end else if (p > {1'b0, PCT_MAX}) begin
            r = PCT_MAX;
        end else begin
            r = p[6:0];
        end
        return r;
    endfunction

    // (p * 255 + 48) / 97 by reciprocal multiply
    function automatic logic [7:0] pct_to_drive(input logic [6:0] p);
        logic [14:0] num;
        logic [30:0] prod;
        num  = {p, 8'd0} - {8'd0, p} + DRIVE_ROUND;
        prod = 31'(num) * 31'(DRIVE_RECIP);
        return prod[29:22];
    endfunction

endpackage

`default_nettype wire

// ===== hw/rtl/bisc_in_stage.sv =====
// Input holding register of the backlight sleep controller.
`default_nettype none

module bisc_in_stage (
    input  wire logic               aclk,
    input  wire logic               aresetn,
    input  wire logic               s_valid,
    output logic                    s_ready,
    input  wire bisc_pkg::in_item_t s_data,
    input  wire logic               advance,
    output logic                    item_valid,
    output bisc_pkg::in_item_t      item
);

    logic               valid_reg;
    logic               valid_next;
    bisc_pkg::in_item_t data_reg;

    assign s_ready    = !valid_reg || advance;
    assign valid_next = (valid_reg && !advance) || (s_valid && s_ready);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
        if (s_valid && s_ready) begin
            data_reg <= s_data;
        end
    end

    assign item_valid = valid_reg;
    assign item       = data_reg;

endmodule

`default_nettype wire

// ===== hw/rtl/bisc_core.sv =====
// Sleep, wake, touch-lock and deferred-save state with its next-state logic.
`default_nettype none

module bisc_core #(
    parameter int SAVE_DELAY_MS   = 400,
    parameter int MAX_TIMEOUT_SEC = 1800
) (
    input  wire logic                 aclk,
    input  wire logic                 aresetn,
    input  wire bisc_pkg::cfg_write_t cfg,
    input  wire logic                 advance,
    input  wire bisc_pkg::in_item_t   item,
    output bisc_pkg::out_item_t       result
);

    localparam int IDLE_CAP  = MAX_TIMEOUT_SEC * bisc_pkg::MS_PER_SEC;
    localparam int IDLE_W    = $clog2(IDLE_CAP + 1);
    localparam int PEND_W    = $clog2(SAVE_DELAY_MS + 1);
    localparam int RESET_TMO = (bisc_pkg::TIMEOUT_RESET > MAX_TIMEOUT_SEC)
                               ? MAX_TIMEOUT_SEC : bisc_pkg::TIMEOUT_RESET;

    logic              sleeping_reg,  sleeping_next;
    logic              ignore_reg,    ignore_next;
    logic [IDLE_W-1:0] idle_reg,      idle_next;
    logic [6:0]        current_reg,   current_next;
    logic [6:0]        saved_reg,     saved_next;
    logic              pend_flag_reg, pend_flag_next;
    logic [PEND_W-1:0] pend_ms_reg,   pend_ms_next;
    logic [IDLE_W-1:0] tmo_ms_reg,    tmo_ms_next;

    logic              wake;
    logic              consumed;
    logic              req;
    logic [6:0]        sval;
    logic [6:0]        new_pct;
    logic [6:0]        cfg_pct;
    logic [IDLE_W-1:0] cfg_tmo;

    // timeout threshold in ms, worked out once at the register write
    assign cfg_tmo = IDLE_W'(cfg.data);
    always_comb begin
        if (cfg_tmo > IDLE_W'(MAX_TIMEOUT_SEC)) begin
            tmo_ms_next = IDLE_W'(IDLE_CAP);
        end else begin
            tmo_ms_next = IDLE_W'(cfg_tmo * IDLE_W'(bisc_pkg::MS_PER_SEC));
        end
    end

    assign cfg_pct = bisc_pkg::clamp_pct({1'b0, cfg.data[6:0]});
    assign new_pct = bisc_pkg::clamp_pct(item.percent);

    always_comb begin
        sleeping_next  = sleeping_reg;
        ignore_next    = ignore_reg;
        idle_next      = idle_reg;
        current_next   = current_reg;
        saved_next     = saved_reg;
        pend_flag_next = pend_flag_reg;
        pend_ms_next   = pend_ms_reg;
        wake           = 1'b0;
        consumed       = 1'b0;
        req            = 1'b0;
        sval           = '0;

        case (item.operation)
            bisc_pkg::OP_TICK: begin
                if (pend_ms_reg < PEND_W'(SAVE_DELAY_MS)) begin
                    pend_ms_next = pend_ms_reg + 1'b1;
                end
                if (idle_reg < IDLE_W'(IDLE_CAP)) begin
                    idle_next = idle_reg + 1'b1;
                end
                // flush a deferred save before the sleep decision
                if (pend_flag_reg && pend_ms_next >= PEND_W'(SAVE_DELAY_MS)) begin
                    if (current_reg != saved_reg) begin
                        saved_next = current_reg;
                        req        = 1'b1;
                        sval       = current_reg;
                    end
                    pend_flag_next = 1'b0;
                end
                if (sleeping_reg) begin
                    wake = item.pressed;
                end else if (tmo_ms_reg != '0 && idle_next >= tmo_ms_reg) begin
                    sleeping_next = 1'b1;
                end
            end
            bisc_pkg::OP_ACTIVITY: begin
                if (!sleeping_reg) begin
                    idle_next = '0;
                end
            end
            bisc_pkg::OP_TOUCH: begin
                if (sleeping_reg) begin
                    wake     = item.pressed;
                    consumed = 1'b1;
                end else if (ignore_reg) begin
                    if (!item.pressed) begin
                        ignore_next = 1'b0;
                    end
                    consumed = 1'b1;
                end
            end
            bisc_pkg::OP_SET_LEVEL: begin
                current_next = new_pct;
                if (item.persist) begin
                    saved_next     = new_pct;
                    pend_flag_next = 1'b0;
                    req            = 1'b1;
                    sval           = new_pct;
                end else if (new_pct != saved_reg) begin
                    pend_flag_next = 1'b1;
                    pend_ms_next   = '0;
                end
                if (!sleeping_reg) begin
                    idle_next = '0;
                end
            end
            bisc_pkg::OP_WAKE: begin
                wake = 1'b1;
            end
            default: begin
            end
        endcase

        // wake; lock touches only when coming out of sleep
        if (wake) begin
            sleeping_next = 1'b0;
            idle_next     = '0;
            if (sleeping_reg) begin
                ignore_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            sleeping_reg  <= 1'b0;
            ignore_reg    <= 1'b0;
            idle_reg      <= '0;
            current_reg   <= bisc_pkg::PCT_RESET;
            saved_reg     <= bisc_pkg::PCT_RESET;
            pend_flag_reg <= 1'b0;
            pend_ms_reg   <= '0;
            tmo_ms_reg    <= IDLE_W'(RESET_TMO * bisc_pkg::MS_PER_SEC);
        end else if (cfg.valid) begin
            case (cfg.index)
                bisc_pkg::CFG_SLEEP_TIMEOUT: begin
                    tmo_ms_reg <= tmo_ms_next;
                end
                bisc_pkg::CFG_STORED_BRIGHTNESS: begin
                    current_reg   <= cfg_pct;
                    saved_reg     <= cfg_pct;
                    pend_flag_reg <= 1'b0;
                    pend_ms_reg   <= '0;
                end
                default: begin
                end
            endcase
        end else if (advance) begin
            sleeping_reg  <= sleeping_next;
            ignore_reg    <= ignore_next;
            idle_reg      <= idle_next;
            current_reg   <= current_next;
            saved_reg     <= saved_next;
            pend_flag_reg <= pend_flag_next;
            pend_ms_reg   <= pend_ms_next;
        end
    end

    // while awake the drive always tracks the current percent
    always_comb begin
        result.backlight_level = sleeping_next ? 8'd0 : bisc_pkg::pct_to_drive(current_next);
        result.asleep          = sleeping_next;
        result.touch_consumed  = consumed;
        result.save_request    = req;
        result.save_value      = sval;
    end

endmodule

`default_nettype wire

// ===== hw/rtl/bisc_out_stage.sv =====
// Result register of the backlight sleep controller.
`default_nettype none

module bisc_out_stage (
    input  wire logic                aclk,
    input  wire logic                aresetn,
    input  wire logic                load,
    input  wire bisc_pkg::out_item_t result,
    output logic                     can_load,
    output logic                     m_valid,
    input  wire logic                m_ready,
    output bisc_pkg::out_item_t      m_data
);

    logic                valid_reg;
    logic                valid_next;
    bisc_pkg::out_item_t data_reg;

    assign can_load   = !valid_reg || m_ready;
    assign valid_next = load || (valid_reg && !m_ready);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
        if (load) begin
            data_reg <= result;
        end
    end

    assign m_valid = valid_reg;
    assign m_data  = data_reg;

endmodule

`default_nettype wire

// ===== hw/rtl/backlight_inactivity_sleep_controller.sv =====
// Top level of the touch-display backlight inactivity sleep controller.
`default_nettype none
`include "backlight_inactivity_sleep_controller_defines.svh"

// Channel   Direction  Ports                               Word
// input     in         s_valid, s_ready, s_data            bisc_pkg::in_item_t
// result    out        m_valid, m_ready, m_data            bisc_pkg::out_item_t
// config    in         cfg_valid, cfg_ready, cfg_index,    register index + data
//                      cfg_data
//
// Throughput is one word per cycle while m_ready stays high; a word's status reaches
// m_data through the input register, then the result register.
// All state updates for one word happen in the single step from the input
// register to the result register; the drive scaling is one reciprocal multiply.
// Reset (aresetn low, synchronous) loads timeout 120 s and brightness 60 %.
// A stalled result register holds the input register, which then drops
// s_ready; configuration writes are always taken (cfg_ready high).

module backlight_inactivity_sleep_controller #(
    parameter int SAVE_DELAY_MS   = 400,
    parameter int MAX_TIMEOUT_SEC = 1800
) (
    input  wire logic                                aclk,
    input  wire logic                                aresetn,
    input  wire logic                                s_valid,
    output logic                                     s_ready,
    input  wire bisc_pkg::in_item_t                  s_data,
    output logic                                     m_valid,
    input  wire logic                                m_ready,
    output bisc_pkg::out_item_t                      m_data,
    input  wire logic                                cfg_valid,
    output logic                                     cfg_ready,
    input  wire logic [bisc_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  wire logic [bisc_pkg::CFG_DATA_W-1:0]     cfg_data
);

    logic                 item_valid;
    bisc_pkg::in_item_t   item;
    bisc_pkg::out_item_t  result;
    bisc_pkg::cfg_write_t cfg;
    logic                 can_load;
    logic                 advance;

    // take a register write whenever offered
    assign cfg_ready = 1'b1;
    assign cfg.valid = cfg_valid;
    assign cfg.index = cfg_index;
    assign cfg.data  = cfg_data;

    // advance the held word when the result register has room
    assign advance = item_valid && can_load;

    bisc_in_stage u_in_stage (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_valid    (s_valid),
        .s_ready    (s_ready),
        .s_data     (s_data),
        .advance    (advance),
        .item_valid (item_valid),
        .item       (item)
    );

    bisc_core #(
        .SAVE_DELAY_MS   (SAVE_DELAY_MS),
        .MAX_TIMEOUT_SEC (MAX_TIMEOUT_SEC)
    ) u_core (
        .aclk    (aclk),
        .aresetn (aresetn),
        .cfg     (cfg),
        .advance (advance),
        .item    (item),
        .result  (result)
    );

    bisc_out_stage u_out_stage (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .load     (advance),
        .result   (result),
        .can_load (can_load),
        .m_valid  (m_valid),
        .m_ready  (m_ready),
        .m_data   (m_data)
    );

    // A sleeping panel is dark.
    `BISC_ASSERT_NOW(a_dark_when_asleep, aclk, aresetn, m_valid && m_data.asleep, m_data.backlight_level == 8'd0, "backlight driven while asleep")
    // Save value is zero without a save strobe.
    `BISC_ASSERT_NOW(a_save_value_idle, aclk, aresetn, m_valid && !m_data.save_request, m_data.save_value == 7'd0, "save value without save request")
    // A saved percent is always within the clamped range.
    `BISC_ASSERT_NOW(a_save_in_range, aclk, aresetn, m_valid && m_data.save_request, m_data.save_value >= bisc_pkg::PCT_MIN && m_data.save_value <= bisc_pkg::PCT_MAX, "save value out of range")
    // An advanced word shows up in the result register next cycle.
    `BISC_ASSERT_NEXT(a_advance_shows, aclk, aresetn, advance, m_valid, "advanced word lost")

endmodule

`default_nettype wire
